/* hw/rtl/fbrt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// fbrt_pkg
// Shared types and constants for the flow bandwidth reservation table.
// ============================================================================
package fbrt_pkg;

    localparam int MaxSessions = 256;
    localparam int IdxW        = $clog2(MaxSessions);
    localparam int CntW        = $clog2(MaxSessions + 1);

    localparam logic [2:0] REQ_PROBE   = 3'd0;
    localparam logic [2:0] REQ_RESERVE = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_DATA    = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MAXSESS = 2'd1;
    localparam logic [1:0] CFG_TOTALBW = 2'd2;
    localparam logic [1:0] CFG_MINLEN  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [47:0] src_endpoint;
        logic [47:0] dst_endpoint;
        logic [15:0] req_bw;
        logic [15:0] pkt_len;
        logic [31:0] now_secs;
    } t_req;

    typedef struct packed {
        logic        forward;
        logic [15:0] granted_bw;
        logic [15:0] free_bw;
        logic [8:0]  session_count;
        logic [1:0]  status;
    } t_rsp;

    // one table entry: key, grant, last-seen time
    typedef struct packed {
        logic [47:0] src;
        logic [47:0] dst;
        logic [15:0] bw;
        logic [31:0] last_seen;
    } t_entry;

    // memory access from the controller
    typedef struct packed {
        logic            rd;
        logic [IdxW-1:0] rd_addr;
        logic            wr;
        logic [IdxW-1:0] wr_addr;
        t_entry          wr_data;
    } t_mem_req;

endpackage

/* hw/rtl/fbrt_mem.sv */
`timescale 1ns / 1ps
// ============================================================================
// fbrt_mem
// Entry store: one write port, one registered read port.
// ============================================================================
module fbrt_mem
    import fbrt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [MaxSessions];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* hw/rtl/flow_bandwidth_reservation_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// flow_bandwidth_reservation_table
// Session table with bandwidth admission, scanned out of one entry memory.
// ============================================================================
// Raise start while busy is low to issue one request; exactly one result
// appears later on o_rsp, marked by o_done for a single cycle, and cannot be
// stalled. Every request walks the entry memory one slot per cycle (one read
// port, registered read data), so busy stays high through the scan and the
// apply step after the accepting edge. The result appears as busy falls,
// which is also the first cycle a new request can be taken, so a new request
// cannot start before the last one's result; the memory scan is the limit.
// Valid bits live in flip-flops, so no clearing pass is needed after reset.
// Configuration writes are always taken (o_cfg_ready is tied high) and must
// be made while idle.
module flow_bandwidth_reservation_table
    import fbrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} t_state;

    t_state          r_state;
    t_req            r_req;
    logic [IdxW:0]   r_idx;      // read address issued, counts to MaxSessions
    logic            r_pend;     // read data valid this cycle
    logic [IdxW-1:0] r_pidx;     // address of that data
    logic [MaxSessions-1:0] r_valid;
    logic [15:0]     r_resv;
    logic [CntW-1:0] r_live;
    logic            r_hit;
    logic [IdxW-1:0] r_hit_idx;
    logic [15:0]     r_hit_bw;
    logic            r_free_ok;
    logic [IdxW-1:0] r_free_idx;
    logic [15:0]     r_tmo, r_tot, r_minlen;
    logic [8:0]      r_maxs;
    logic            r_done;
    t_rsp            r_rsp;

    t_mem_req mreq;
    t_entry   rd;

    fbrt_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rd_data(rd));

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // comparison on the entry read back this cycle
    logic match, aged;
    assign match = r_valid[r_pidx] && rd.src == r_req.src_endpoint
                   && rd.dst == r_req.dst_endpoint;
    assign aged  = r_valid[r_pidx]
                   && ((r_req.now_secs - rd.last_seen) > {16'd0, r_tmo});

    // apply-step arithmetic
    logic [15:0] base_resv, avail, clip, new_resv;
    logic [CntW-1:0] limit;
    logic full;
    assign limit = ({1'b0, r_maxs} < 10'(MaxSessions)) ? CntW'(r_maxs)
                                                      : CntW'(MaxSessions);
    assign base_resv = r_hit ? (r_resv - r_hit_bw) : r_resv;
    assign avail = (r_tot > base_resv) ? (r_tot - base_resv) : 16'd0;
    assign clip  = (r_req.req_bw <= avail) ? r_req.req_bw : avail;
    assign full  = !(r_live < limit) || !r_free_ok;
    assign new_resv = base_resv + clip;

    // memory port: scan reads, apply writes
    always_comb begin
        mreq = '0;
        mreq.rd      = (r_state == S_SCAN) && !r_idx[IdxW];
        mreq.rd_addr = r_idx[IdxW-1:0];
        if (r_state == S_APPLY) begin
            mreq.wr_data.src       = r_req.src_endpoint;
            mreq.wr_data.dst       = r_req.dst_endpoint;
            mreq.wr_data.last_seen = r_req.now_secs;
            if (r_req.req_type == REQ_RESERVE) begin
                mreq.wr      = r_hit || !full;
                mreq.wr_addr = r_hit ? r_hit_idx : r_free_idx;
                mreq.wr_data.bw = (r_hit && r_req.req_bw == r_hit_bw) ? r_hit_bw
                                                                      : clip;
            end else if (r_req.req_type == REQ_DATA) begin
                mreq.wr      = r_hit && !(r_req.pkt_len < r_minlen);
                mreq.wr_addr = r_hit_idx;
                mreq.wr_data.bw = r_hit_bw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_resv  <= '0;
            r_live  <= '0;
            r_pend  <= 1'b0;
            r_tmo   <= 16'd20;
            r_maxs  <= 9'd200;
            r_tot   <= 16'hFFFF;
            r_minlen <= 16'd13;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIMEOUT: r_tmo    <= i_cfg_data;
                    CFG_MAXSESS: r_maxs   <= i_cfg_data[8:0];
                    CFG_TOTALBW: r_tot    <= i_cfg_data;
                    CFG_MINLEN:  r_minlen <= i_cfg_data;
                    default:     r_tmo    <= r_tmo;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req     <= i_req;
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_idx[IdxW]) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_pend <= mreq.rd;
                    r_pidx <= r_idx[IdxW-1:0];
                    if (r_pend) begin
                        if (!r_valid[r_pidx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                        if (match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_pidx;
                            r_hit_bw  <= rd.bw;
                        end
                        if (r_req.req_type == REQ_TICK && aged) begin
                            r_valid[r_pidx] <= 1'b0;
                            r_resv <= r_resv - rd.bw;
                            r_live <= r_live - 1'b1;
                        end
                    end else if (r_idx[IdxW]) begin
                        r_state <= S_APPLY;
                    end
                end
                default: begin
                    r_rsp <= '0;
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    case (r_req.req_type)
                        REQ_RESERVE: begin
                            if (r_hit) begin
                                if (r_req.req_bw == r_hit_bw) begin
                                    r_rsp.granted_bw <= r_hit_bw;
                                    r_rsp.free_bw <= (r_tot > r_resv) ? r_tot - r_resv
                                                                      : 16'd0;
                                end else begin
                                    r_resv <= new_resv;
                                    r_rsp.granted_bw <= clip;
                                    r_rsp.free_bw <= (r_tot > new_resv) ? r_tot - new_resv
                                                                        : 16'd0;
                                end
                                r_rsp.session_count <= 9'(r_live);
                            end else if (full) begin
                                r_rsp.granted_bw <= clip;
                                r_rsp.status <= ST_FULL;
                                r_rsp.free_bw <= avail;
                                r_rsp.session_count <= 9'(r_live);
                            end else begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_resv <= new_resv;
                                r_live <= r_live + 1'b1;
                                r_rsp.granted_bw <= clip;
                                r_rsp.free_bw <= (r_tot > new_resv) ? r_tot - new_resv
                                                                    : 16'd0;
                                r_rsp.session_count <= 9'(r_live + 1'b1);
                            end
                        end
                        REQ_RELEASE: begin
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                                r_resv <= r_resv - r_hit_bw;
                                r_live <= r_live - 1'b1;
                                r_rsp.free_bw <= (r_tot > 16'(r_resv - r_hit_bw))
                                                 ? 16'(r_tot - (r_resv - r_hit_bw)) : 16'd0;
                                r_rsp.session_count <= 9'(r_live - 1'b1);
                            end else begin
                                r_rsp.status <= ST_NOTFOUND;
                                r_rsp.free_bw <= (r_tot > r_resv) ? r_tot - r_resv
                                                                  : 16'd0;
                                r_rsp.session_count <= 9'(r_live);
                            end
                        end
                        REQ_DATA: begin
                            if (r_req.pkt_len < r_minlen) begin
                                r_rsp.status <= ST_SHORT;
                            end else if (r_hit) begin
                                r_rsp.forward <= 1'b1;
                            end else begin
                                r_rsp.status <= ST_NOTFOUND;
                            end
                            r_rsp.free_bw <= (r_tot > r_resv) ? r_tot - r_resv : 16'd0;
                            r_rsp.session_count <= 9'(r_live);
                        end
                        default: begin
                            r_rsp.free_bw <= (r_tot > r_resv) ? r_tot - r_resv : 16'd0;
                            r_rsp.session_count <= 9'(r_live);
                        end
                    endcase
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CntW'(MaxSessions)) else $error("live count overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done while busy");
    a_live_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> 32'($countones(r_valid)) == 32'(r_live))
        else $error("valid bits and live count disagree");
`endif

endmodule

/* tb/sv/tb_flow_bandwidth_reservation_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_flow_bandwidth_reservation_table
// Self-checking bench for the session table with bandwidth admission. A
// shadow table in a scoreboard class predicts each response word; directed
// and random requests run under several register settings.
// ============================================================================

import fbrt_pkg::*;

class session_scoreboard;
    bit          slot_used [MaxSessions];
    logic [47:0] slot_src  [MaxSessions];
    logic [47:0] slot_dst  [MaxSessions];
    logic [15:0] slot_bw   [MaxSessions];
    logic [31:0] slot_seen [MaxSessions];
    logic [15:0] sum_bw;
    int          live;
    logic [15:0] timeout_s;
    logic [8:0]  max_sess;
    logic [15:0] budget;
    logic [15:0] min_len;
    t_rsp        pending[$];
    int          errors;

    function void clear();
        foreach (slot_used[i]) slot_used[i] = 0;
        sum_bw = 0; live = 0;
        timeout_s = 20; max_sess = 200; budget = 16'hFFFF; min_len = 13;
        pending.delete();
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_TIMEOUT: timeout_s = val;
            CFG_MAXSESS: max_sess  = val[8:0];
            CFG_TOTALBW: budget    = val;
            default:     min_len   = val;
        endcase
    endfunction

    function logic [15:0] spare();
        return (budget > sum_bw) ? budget - sum_bw : 16'd0;
    endfunction

    function int lookup(logic [47:0] s, logic [47:0] d);
        foreach (slot_used[i])
            if (slot_used[i] && slot_src[i] == s && slot_dst[i] == d) return i;
        return -1;
    endfunction

    function void drop(int i);
        sum_bw = sum_bw - slot_bw[i];
        slot_used[i] = 0;
        live--;
    endfunction

    // note one accepted request word and queue the predicted response
    function void note_request(t_req r);
        t_rsp        p;
        int          s, cap;
        logic [15:0] avail;
        p = '0;
        cap = (max_sess < MaxSessions) ? max_sess : MaxSessions;
        case (r.req_type)
            REQ_RESERVE: begin
                s = lookup(r.src_endpoint, r.dst_endpoint);
                if (s >= 0) begin
                    if (r.req_bw != slot_bw[s]) begin
                        sum_bw = sum_bw - slot_bw[s];
                        avail = spare();
                        slot_bw[s] = (r.req_bw <= avail) ? r.req_bw : avail;
                        sum_bw = sum_bw + slot_bw[s];
                    end
                    p.granted_bw = slot_bw[s];
                    slot_seen[s] = r.now_secs;
                end else begin
                    avail = spare();
                    p.granted_bw = (r.req_bw <= avail) ? r.req_bw : avail;
                    s = -1;
                    foreach (slot_used[i]) if (s < 0 && !slot_used[i]) s = i;
                    if (live < cap && s >= 0) begin
                        slot_used[s] = 1;
                        slot_src[s] = r.src_endpoint;
                        slot_dst[s] = r.dst_endpoint;
                        slot_bw[s] = p.granted_bw;
                        slot_seen[s] = r.now_secs;
                        sum_bw = sum_bw + p.granted_bw;
                        live++;
                    end else p.status = ST_FULL;
                end
            end
            REQ_RELEASE: begin
                s = lookup(r.src_endpoint, r.dst_endpoint);
                if (s >= 0) drop(s);
                else p.status = ST_NOTFOUND;
            end
            REQ_DATA: begin
                if (r.pkt_len < min_len) p.status = ST_SHORT;
                else begin
                    s = lookup(r.src_endpoint, r.dst_endpoint);
                    if (s >= 0) begin
                        slot_seen[s] = r.now_secs;
                        p.forward = 1;
                    end else p.status = ST_NOTFOUND;
                end
            end
            REQ_TICK: begin
                foreach (slot_used[i])
                    if (slot_used[i] && (r.now_secs - slot_seen[i]) > {16'd0, timeout_s})
                        drop(i);
            end
            default: ;
        endcase
        p.free_bw = spare();
        p.session_count = live[8:0];
        pending.push_back(p);
    endfunction

    function void check_response(t_rsp got);
        t_rsp want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response word %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: fwd %0d/%0d grant %0d/%0d free %0d/%0d cnt %0d/%0d st %0d/%0d",
                         want.forward, got.forward, want.granted_bw, got.granted_bw,
                         want.free_bw, got.free_bw, want.session_count, got.session_count,
                         want.status, got.status);
        end
    endfunction
endclass

module tb_flow_bandwidth_reservation_table;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    session_scoreboard sb;

    // small pool of endpoint keys so lookups hit; keys 0 and 2 use all-ones bits
    logic [47:0] key_src [16];
    logic [47:0] key_dst [16];
    logic [31:0] clock_s;

    flow_bandwidth_reservation_table dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // responses cannot be stalled: check every done cycle at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && o_done) sb.check_response(o_rsp);

    // hard stop: 1451 requests plus the longest gaps stay well below this
    initial begin
        #50_000_000;
        $display("tb_flow_bandwidth_reservation_table failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
        repeat (n) @(negedge i_clk);
    endtask

    // one request word: wait for not busy, hold start through one accepting edge
    task automatic issue(t_req r);
        while (busy) @(negedge i_clk);
        i_req = r;
        start = 1'b1;
        @(posedge i_clk);
        sb.note_request(r);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for all predicted words, plus a full scan for safety
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (MaxSessions + 10) @(negedge i_clk);
    endtask

    function automatic t_req make_req(logic [2:0] op, int k, logic [15:0] bw,
                                      logic [15:0] len, logic [31:0] now);
        t_req r;
        r.req_type = op;
        r.src_endpoint = key_src[k];
        r.dst_endpoint = key_dst[k];
        r.req_bw = bw;
        r.pkt_len = len;
        r.now_secs = now;
        return r;
    endfunction

    task automatic random_phase(int n, int keys);
        t_req r;
        int   pick;
        for (int j = 0; j < n; j++) begin
            pick = int'($urandom_range(0, 99));
            clock_s = clock_s + $urandom_range(0, 6);
            r = make_req(REQ_PROBE, int'($urandom_range(0, keys - 1)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40)), clock_s);
            if (pick < 35) r.req_type = REQ_RESERVE;
            else if (pick < 50) r.req_type = REQ_RELEASE;
            else if (pick < 85) r.req_type = REQ_DATA;
            else if (pick < 92) r.req_type = REQ_TICK;
            else if (pick < 96) r.req_type = REQ_PROBE;
            else r.req_type = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 7) == 0) r.pkt_len = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0) r.req_bw = 16'($urandom_range(0, 3000));
            if ($urandom_range(0, 15) == 0) begin
                // unknown random key, exercises every key bit
                r.src_endpoint = 48'({$urandom(), $urandom()});
                r.dst_endpoint = 48'({$urandom(), $urandom()});
            end
            if ($urandom_range(0, 20) == 0) r.now_secs = $urandom();
            issue(r);
            if ($urandom_range(0, 2) == 0) idle_gap();
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TIMEOUT;
        i_cfg_data = '0;
        clock_s = 32'd1000;
        for (int k = 0; k < 16; k++) begin
            key_src[k] = 48'({$urandom(), $urandom()});
            key_dst[k] = 48'({$urandom(), $urandom()});
        end
        key_src[0] = '1; key_dst[0] = '1;
        key_src[1] = '0; key_dst[1] = '0;
        key_src[2] = '1; key_dst[2] = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, every op and the corner cases
        issue(make_req(REQ_PROBE, 0, 0, 0, 0));
        issue(make_req(REQ_RESERVE, 0, 16'hFFFF, 0, 32'hFFFF_FFFF));
        issue(make_req(REQ_RESERVE, 1, 100, 0, 5));          // budget exhausted
        issue(make_req(REQ_RESERVE, 0, 16'hFFFF, 0, 6));     // same grant kept
        issue(make_req(REQ_RESERVE, 0, 1000, 0, 7));         // new grant
        issue(make_req(REQ_RESERVE, 2, 500, 0, 7));
        issue(make_req(REQ_DATA, 0, 0, 12, 8));              // too short
        issue(make_req(REQ_DATA, 0, 0, 16'hFFFF, 8));
        issue(make_req(REQ_DATA, 5, 0, 13, 8));              // unknown
        issue(make_req(REQ_RELEASE, 5, 0, 0, 8));            // release unknown
        issue(make_req(REQ_RELEASE, 2, 0, 0, 8));
        issue(make_req(3'd7, 0, 0, 0, 8));
        issue(make_req(3'd5, 0, 0, 0, 8));
        issue(make_req(REQ_TICK, 0, 0, 0, 28));              // not yet expired
        issue(make_req(REQ_TICK, 0, 0, 0, 29));              // ages out
        drain();

        // tight limit, small budget, then zero budget and limit after the tick
        write_reg(CFG_MAXSESS, 16'd2);
        write_reg(CFG_TOTALBW, 16'd3000);
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_MINLEN, 16'd0);
        issue(make_req(REQ_RESERVE, 3, 2000, 0, 40));
        issue(make_req(REQ_RESERVE, 4, 2000, 0, 40));
        issue(make_req(REQ_RESERVE, 5, 2000, 0, 40));        // table full
        issue(make_req(REQ_DATA, 3, 0, 0, 40));
        issue(make_req(REQ_TICK, 0, 0, 0, 41));
        drain();
        write_reg(CFG_TOTALBW, 16'd0);
        write_reg(CFG_MAXSESS, 16'd0);
        issue(make_req(REQ_RESERVE, 6, 10, 0, 50));
        random_phase(200, 6);
        drain();                                             // sender waits out all words

        write_reg(CFG_MAXSESS, 16'd256);
        write_reg(CFG_TOTALBW, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_MINLEN, 16'hFFFF);
        random_phase(300, 16);
        drain();

        write_reg(CFG_MAXSESS, 16'd8);
        write_reg(CFG_TOTALBW, 16'd5000);
        write_reg(CFG_TIMEOUT, 16'd15);
        write_reg(CFG_MINLEN, 16'd13);
        random_phase(500, 16);
        drain();

        write_reg(CFG_MAXSESS, 16'd3);
        write_reg(CFG_TIMEOUT, 16'd4);
        write_reg(CFG_MINLEN, 16'd20);
        random_phase(430, 12);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_flow_bandwidth_reservation_table passed");
        else
            $display("tb_flow_bandwidth_reservation_table failed");
        $finish;
    end

endmodule
